// ===== src/base64_padded_codec_macros.svh =====
// ----------------------------------------------------------------------------
// base64 codec assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BASE64_PADDED_CODEC_MACROS_SVH
`define BASE64_PADDED_CODEC_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B64_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64 codec check failed");

// next-cycle implication
`define B64_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 codec check failed");

`else

`define B64_ASSERT_IMPLIES(label, ante, cons)
`define B64_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// b64_pkg
// shared types, constants and alphabet functions of the base64 codec
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR   = 8'h3d;
	localparam logic [7:0] PLUS_CHAR  = 8'h2b;
	localparam logic [7:0] SLASH_CHAR = 8'h2f;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_LEN = 1'b1;

	// one group handed from the front end to the output stage
	typedef struct packed {
		logic [23:0] bits;   // group, left aligned
		logic        mode;   // MODE_ENCODE or MODE_DECODE
		logic        err;    // bad decode length
		logic        last;   // group closes the message
		logic [2:0]  num;    // characters (encode) or bytes (decode) carrying data
	} job_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26)
			r = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			r = 8'h61 + ({2'b00, v} - 8'd26);
		else if (v < 6'd62)
			r = 8'h30 + ({2'b00, v} - 8'd52);
		else if (v == 6'd62)
			r = PLUS_CHAR;
		else
			r = SLASH_CHAR;
		return r;
	endfunction

	function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
		logic [5:0] r;
		if (c >= 8'h41 && c <= 8'h5a)
			r = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7a)
			r = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			r = 6'(c - 8'h30 + 8'd52);
		else if (c == PLUS_CHAR)
			r = 6'd62;
		else if (c == SLASH_CHAR)
			r = 6'd63;
		else
			r = 6'd0;
		return r;
	endfunction

endpackage

// ===== src/b64_front.sv =====
// ----------------------------------------------------------------------------
// b64_front
// accepts bytes or characters, gathers groups and issues one job per group
// ----------------------------------------------------------------------------
module b64_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_data,
	input  logic             push,
	input  logic [7:0]       in_byte,
	input  logic             is_last,
	input  logic             job_full,
	output logic             job_push,
	output b64_pkg::job_t    job
);

	logic        mode_q;
	logic [23:0] group_bits_q;
	logic [1:0]  group_fill_q;
	logic        pad_prev_q;

	logic        accept;
	logic [1:0]  enc_fill;
	logic [23:0] enc_bits;
	logic [5:0]  sextet;
	logic [23:0] dec_bits;
	logic        is_pad;

	logic [23:0] bits_d;
	logic [1:0]  fill_d;
	logic        pad_prev_d;

	assign accept = push && !job_full;
	assign is_pad = (in_byte == b64_pkg::PAD_CHAR);
	assign sextet = b64_pkg::char_to_sextet(in_byte);

	// a fill of three never occurs when encoding, treat it as empty
	assign enc_fill = (group_fill_q == 2'd3) ? 2'd0 : group_fill_q;

	always_comb begin
		unique case (enc_fill)
			2'd0:    enc_bits = group_bits_q | {in_byte, 16'h0000};
			2'd1:    enc_bits = group_bits_q | {8'h00, in_byte, 8'h00};
			default: enc_bits = group_bits_q | {16'h0000, in_byte};
		endcase
	end

	always_comb begin
		unique case (group_fill_q)
			2'd0:    dec_bits = group_bits_q | {sextet, 18'h0};
			2'd1:    dec_bits = group_bits_q | {6'h0, sextet, 12'h0};
			2'd2:    dec_bits = group_bits_q | {12'h0, sextet, 6'h0};
			default: dec_bits = group_bits_q | {18'h0, sextet};
		endcase
	end

	always_comb begin
		job_push   = 1'b0;
		job.bits   = 24'h0;
		job.mode   = mode_q;
		job.err    = 1'b0;
		job.last   = is_last;
		job.num    = 3'd0;
		bits_d     = group_bits_q;
		fill_d     = group_fill_q;
		pad_prev_d = pad_prev_q;
		if (mode_q == b64_pkg::MODE_ENCODE) begin
			job.bits = enc_bits;
			job.num  = {1'b0, enc_fill} + 3'd2;
			if (enc_fill == 2'd2 || is_last) begin
				job_push   = accept;
				bits_d     = 24'h0;
				fill_d     = 2'd0;
				pad_prev_d = 1'b0;
			end else begin
				bits_d = enc_bits;
				fill_d = enc_fill + 2'd1;
			end
		end else begin
			job.bits = dec_bits;
			if (group_fill_q != 2'd3) begin
				if (is_last) begin
					// short final group
					job_push   = accept;
					job.err    = 1'b1;
					job.num    = 3'd1;
					bits_d     = 24'h0;
					fill_d     = 2'd0;
					pad_prev_d = 1'b0;
				end else begin
					bits_d = dec_bits;
					fill_d = group_fill_q + 2'd1;
					if (group_fill_q == 2'd2)
						pad_prev_d = is_pad;
				end
			end else begin
				job_push = accept;
				if (is_last && is_pad)
					job.num = pad_prev_q ? 3'd1 : 3'd2;
				else
					job.num = 3'd3;
				bits_d     = 24'h0;
				fill_d     = 2'd0;
				pad_prev_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= b64_pkg::MODE_ENCODE;
			group_bits_q <= 24'h0;
			group_fill_q <= 2'd0;
			pad_prev_q   <= 1'b0;
		end else if (cfg_valid) begin
			// a mode write abandons any partial group
			mode_q       <= cfg_data;
			group_bits_q <= 24'h0;
			group_fill_q <= 2'd0;
			pad_prev_q   <= 1'b0;
		end else if (accept) begin
			group_bits_q <= bits_d;
			group_fill_q <= fill_d;
			pad_prev_q   <= pad_prev_d;
		end
	end

endmodule

// ===== src/b64_queue.sv =====
// ----------------------------------------------------------------------------
// b64_queue
// short job queue between the front end and the output stage
// ----------------------------------------------------------------------------
module b64_queue #(
	parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  b64_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output b64_pkg::job_t rd_data,
	output logic          not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64_pkg::job_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== src/b64_back.sv =====
// ----------------------------------------------------------------------------
// b64_back
// output stage: holds one job and, while pop is high, issues its results one per cycle
// ----------------------------------------------------------------------------
module b64_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  b64_pkg::job_t job_in,
	output logic          job_pop,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          status
);

	b64_pkg::job_t job_q;
	logic          valid_q;
	logic [1:0]    idx_q;

	logic [2:0]    total;
	logic          final_res;
	logic          taken;
	logic [5:0]    sextet;
	logic [7:0]    dec_byte;

	assign total = (job_q.mode == b64_pkg::MODE_ENCODE) ? 3'd4 :
	               (job_q.err ? 3'd1 : job_q.num);
	assign final_res = ({1'b0, idx_q} == total - 3'd1);
	assign taken     = valid_q && pop;
	assign job_pop   = job_valid && (!valid_q || (taken && final_res));
	assign empty     = !valid_q;

	always_comb begin
		unique case (idx_q)
			2'd0: begin sextet = job_q.bits[23:18]; dec_byte = job_q.bits[23:16]; end
			2'd1: begin sextet = job_q.bits[17:12]; dec_byte = job_q.bits[15:8];  end
			2'd2: begin sextet = job_q.bits[11:6];  dec_byte = job_q.bits[7:0];   end
			default: begin sextet = job_q.bits[5:0]; dec_byte = 8'h00; end
		endcase
	end

	always_comb begin
		if (job_q.mode == b64_pkg::MODE_ENCODE) begin
			out_byte = ({1'b0, idx_q} < job_q.num) ? b64_pkg::sextet_to_char(sextet)
			                                        : b64_pkg::PAD_CHAR;
			status   = b64_pkg::STATUS_OK;
		end else if (job_q.err) begin
			out_byte = 8'h00;
			status   = b64_pkg::STATUS_BAD_LEN;
		end else begin
			out_byte = dec_byte;
			status   = b64_pkg::STATUS_OK;
		end
		out_last = job_q.err || (job_q.last && final_res);
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (job_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (taken) begin
			if (final_res)
				valid_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== src/base64_padded_codec.sv =====
// ----------------------------------------------------------------------------
// base64_padded_codec
// streaming base64 encoder and decoder with '=' padding
// ----------------------------------------------------------------------------
// usage
//   input side behaves as a queue: a transfer happens when push is high and
//   full is low; in_byte carries a data byte (encode) or a character (decode),
//   is_last flags the final item of a message
//   result side behaves as a queue: while empty is low the oldest result sits
//   on out_byte/out_last/status, and a transfer happens when pop is high
//   cfg_valid/cfg_data write decode_mode (0 encode, 1 decode); cfg_ready is
//   always high; a write also drops any partial group, so write only when idle
// timing
//   an item that closes a group is written to the job queue and then loaded
//   into the output stage before its first result shows; while pop is high
//   one result leaves per cycle, and while full is low the front end takes
//   one item per cycle
// stalls and reset
//   a held-off pop keeps the result steady; full rises once the job queue and
//   the output stage hold jobs; arst_n clears the mode, partial group and queues
// ----------------------------------------------------------------------------
`include "base64_padded_codec_macros.svh"

module base64_padded_codec #(
	parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// item input
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	// results
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       status
);

	b64_pkg::job_t front_job;
	b64_pkg::job_t queue_job;
	logic          job_push;
	logic          job_full;
	logic          job_valid;
	logic          job_pop;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign full      = job_full;

	// front end: group gathering and classification
	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push),
		.in_byte   (in_byte),
		.is_last   (is_last),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (front_job)
	);

	// decoupling queue
	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_data   (front_job),
		.full      (job_full),
		.rd_en     (job_pop),
		.rd_data   (queue_job),
		.not_empty (job_valid)
	);

	// output stage: one result per cycle while pop is high
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_in    (queue_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.status    (status)
	);

	// a job is never offered to a full queue
	`B64_ASSERT_IMPLIES(a_no_queue_overflow, job_push, !job_full)
	// a bad-length result always closes its message
	`B64_ASSERT_IMPLIES(a_err_is_last, !empty && status, out_last)
	// a waiting result is not lost while the receiver stalls
	`B64_ASSERT_NEXT(a_result_kept, !empty && !pop, !empty)

endmodule
